// ----- sv/abcws_pkg.sv -----
// Shared types and constants for the adaptive budget cascade work scheduler.
// No dependencies; imported by every module of the block.
package abcws_pkg;

    localparam int MAX_CASCADES     = 8;
    localparam int MAX_DIRTY_BRICKS = 4096;
    localparam int PASS_LIMIT       = 32;
    localparam int DIV_W            = 40;
    localparam int DSR_W            = 32;

    localparam logic [2:0] ST_WRITTEN   = 3'd0;
    localparam logic [2:0] ST_NO_REV    = 3'd1;
    localparam logic [2:0] ST_CLEAN     = 3'd2;
    localparam logic [2:0] ST_CONVERGED = 3'd3;
    localparam logic [2:0] ST_NO_GROUPS = 3'd4;
    localparam logic [2:0] ST_DISPATCH  = 3'd5;

    localparam logic [1:0] CFG_CASCADE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SPEED_LEVEL   = 2'd1;

    typedef enum logic [1:0] {
        t_div_meas = 2'd0,
        t_div_bud  = 2'd1
    } t_div_op;

    typedef struct packed {
        logic       capture;
        logic       do_write;
        logic       emit;
        logic [2:0] emit_status;
        logic       clear_run;
        logic       rev_update;
        logic       div_start;
        t_div_op    div_op;
        logic       take_meas;
        logic       take_avg;
        logic       take_bud;
        logic       scan_init;
        logic       scan_step;
        logic       scan_hit;
        logic       dispatch;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic cc_zero;
        logic rev_zero;
        logic any_dirty;
        logic cost_skip;
        logic cost_zero;
        logic div_done;
        logic hit;
        logic scan_last;
        logic out_busy;
    } t_stat;

    function automatic logic [31:0] target_ns(input logic [1:0] lvl);
        case (lvl)
            2'd0:    target_ns = 32'd2000000;
            2'd2:    target_ns = 32'd350000;
            default: target_ns = 32'd1000000;
        endcase
    endfunction

endpackage

// ----- sv/abcws_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on abcws_pkg for operand widths.
module abcws_div import abcws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_q;
    logic [DSR_W:0]   r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [DSR_W:0]   n_shift;

    assign n_shift = {r_rem[DSR_W-1:0], r_q[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (n_shift >= {1'b0, r_dsr}) begin
                r_rem <= n_shift - {1'b0, r_dsr};
                r_q   <= {r_q[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q   <= {r_q[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- sv/abcws_ctrl.sv -----
// Sequencer for the scheduler: decodes an item and steps the datapath.
// Depends on abcws_pkg for command and status structs.
module abcws_ctrl import abcws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DECODE   = 11'b00000000010,
        S_COST     = 11'b00000000100,
        S_WAIT_MS  = 11'b00000001000,
        S_WAIT_AVG = 11'b00000010000,
        S_BUDGET   = 11'b00000100000,
        S_WAIT_BUD = 11'b00001000000,
        S_SCANINIT = 11'b00010000000,
        S_SCAN     = 11'b00100000000,
        S_DISP     = 11'b01000000000,
        S_SETTLE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.out_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_write) begin
                    o_cmd.do_write = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_WRITTEN;
                    n_state = S_IDLE;
                end else if (i_stat.cc_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_NO_GROUPS;
                    n_state = S_IDLE;
                end else if (i_stat.rev_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_NO_REV;
                    n_state = S_IDLE;
                end else if (!i_stat.any_dirty) begin
                    o_cmd.clear_run = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_CLEAN;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rev_update = 1'b1;
                    n_state = S_COST;
                end
            end
            S_COST: begin
                if (i_stat.cost_skip) begin
                    n_state = S_BUDGET;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op = t_div_meas;
                    n_state = S_WAIT_MS;
                end
            end
            S_WAIT_MS: begin
                if (i_stat.div_done) begin
                    if (i_stat.cost_zero) begin
                        o_cmd.take_meas = 1'b1;
                        n_state = S_SETTLE;
                    end else begin
                        n_state = S_WAIT_AVG;
                    end
                end
            end
            // Fold the latched measurement into the running cost.
            S_WAIT_AVG: begin
                o_cmd.take_avg = 1'b1;
                n_state = S_SETTLE;
            end
            S_SETTLE: n_state = S_BUDGET;
            S_BUDGET: begin
                if (i_stat.cost_zero) begin
                    n_state = S_SCANINIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op = t_div_bud;
                    n_state = S_WAIT_BUD;
                end
            end
            S_WAIT_BUD: begin
                if (i_stat.div_done) begin
                    o_cmd.take_bud = 1'b1;
                    n_state = S_SCANINIT;
                end
            end
            S_SCANINIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state = S_DISP;
                end else if (i_stat.scan_last) begin
                    o_cmd.clear_run = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_status = ST_CONVERGED;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DISP: begin
                o_cmd.dispatch = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ----- sv/abcws_dp.sv -----
// Datapath: cascade tables, cost and budget registers, scan and output register.
// Depends on abcws_pkg and abcws_div.
module abcws_dp import abcws_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_req_type,
    input  logic [2:0]  i_cascade_sel,
    input  logic [12:0] i_dirty_bricks,
    input  logic [63:0] i_dirty_revision,
    input  logic [23:0] i_gpu_time_ns,
    output logic        o_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_cascade,
    output logic [17:0] o_probe_offset,
    output logic [12:0] o_group_count
);
    logic [3:0]  r_cc_raw;
    logic [1:0]  r_speed;
    logic        r_req;
    logic [2:0]  r_sel;
    logic [12:0] r_bricks;
    logic [63:0] r_rev_in;
    logic [23:0] r_time;
    logic [12:0] r_dirty [MAX_CASCADES];
    logic [12:0] r_next  [MAX_CASCADES];
    logic [5:0]  r_passes[MAX_CASCADES];
    logic [63:0] r_rev;
    logic [2:0]  r_rr, r_cand, r_step;
    logic [12:0] r_last;
    logic [31:0] r_cost;
    logic [15:0] r_budget;
    logic [31:0] r_meas;
    logic        r_valid;
    logic [2:0]  r_st, r_co;
    logic [17:0] r_off;
    logic [12:0] r_cnt;

    logic [3:0]       cc;
    logic             any;
    logic [DIV_W-1:0] div_a, div_q;
    logic [DSR_W-1:0] div_b;
    logic             div_done;
    logic [2:0]       cand_nx, start_idx;
    logic [15:0]      lo, hi, want_c;
    logic [16:0]      dbl;
    logic [12:0]      tot, offs, remn, cnt, nsum;
    logic             avg_up;
    logic [31:0]      avg_d, avg_v;
    logic [63:0]      avg_p;

    assign cc = (r_cc_raw > 4'(MAX_CASCADES)) ? 4'(MAX_CASCADES) : r_cc_raw;

    always_comb begin
        any = 1'b0;
        for (int k = 0; k < MAX_CASCADES; k++)
            if (4'(k) < cc && r_dirty[k] != '0) any = 1'b1;
    end

    // Reduce the pointer modulo the cascade count by repeated subtraction.
    always_comb begin
        logic [3:0] v;
        v = {1'b0, r_rr};
        for (int k = 0; k < MAX_CASCADES; k++)
            if (v >= cc) v = v - cc;
        start_idx = v[2:0];
    end

    assign cand_nx = ({1'b0, r_cand} + 4'd1 == cc) ? 3'd0 : r_cand + 3'd1;

    always_comb begin
        case (i_cmd.div_op)
            t_div_meas: begin
                div_a = DIV_W'({r_time, 8'd0});
                div_b = DSR_W'(r_last);
            end
            default: begin
                div_a = DIV_W'({target_ns(r_speed), 8'd0});
                div_b = r_cost;
            end
        endcase
    end

    abcws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // 4:1 average as old + (new - old)/5, floored; the divide by five is a
    // 32-bit reciprocal multiply, and a falling cost rounds the step up.
    always_comb begin
        avg_up = (r_meas >= r_cost);
        avg_d  = avg_up ? (r_meas - r_cost) : (r_cost - r_meas - 32'd1);
        avg_p  = {32'd0, avg_d} * 64'h0000_0000_CCCC_CCCD;
        avg_v  = avg_up ? (r_cost + {2'b00, avg_p[63:34]})
                        : (r_cost - {2'b00, avg_p[63:34]} - 32'd1);
    end

    // Clamp the budget to half and double of its previous value.
    always_comb begin
        lo  = (r_budget >> 1) == '0 ? 16'd1 : (r_budget >> 1);
        dbl = {r_budget, 1'b0};
        if (dbl < 17'd2)          hi = 16'd2;
        else if (dbl > 17'd65535) hi = 16'hFFFF;
        else                      hi = dbl[15:0];
        if (div_q < DIV_W'(lo))      want_c = lo;
        else if (div_q > DIV_W'(hi)) want_c = hi;
        else                         want_c = div_q[15:0];
    end

    always_comb begin
        tot  = r_dirty[r_cand];
        offs = (r_next[r_cand] > tot) ? tot : r_next[r_cand];
        remn = tot - offs;
        cnt  = ({3'b0, remn} > r_budget) ? r_budget[12:0] : remn;
        nsum = offs + cnt;
    end

    always_comb begin
        o_stat.is_write  = !r_req;
        o_stat.cc_zero   = (cc == '0);
        o_stat.rev_zero  = (r_rev_in == '0);
        o_stat.any_dirty = any;
        o_stat.cost_skip = (r_time == '0) || (r_last == '0);
        o_stat.cost_zero = (r_cost == '0);
        o_stat.div_done  = div_done;
        o_stat.hit       = (r_dirty[r_cand] != '0) && (r_passes[r_cand] < 6'(PASS_LIMIT));
        o_stat.scan_last = ({1'b0, r_step} == cc - 4'd1);
        o_stat.out_busy  = r_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_sel    <= i_cascade_sel;
            r_bricks <= i_dirty_bricks;
            r_rev_in <= i_dirty_revision;
            r_time   <= i_gpu_time_ns;
        end
        if (div_done && i_cmd.div_op == t_div_meas) r_meas <= div_q[31:0];
        if (i_cmd.scan_init) begin
            r_cand <= start_idx;
            r_step <= '0;
        end else if (i_cmd.scan_step) begin
            r_cand <= cand_nx;
            r_step <= r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_raw <= 4'd4;
            r_speed  <= 2'd1;
            r_rev    <= '0;
            r_rr     <= '0;
            r_last   <= '0;
            r_cost   <= '0;
            r_budget <= 16'd1;
            r_valid  <= 1'b0;
            for (int k = 0; k < MAX_CASCADES; k++) begin
                r_dirty[k]  <= '0;
                r_next[k]   <= '0;
                r_passes[k] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_CASCADE_COUNT) r_cc_raw <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_SPEED_LEVEL)   r_speed  <= i_cfg_data[1:0];
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            if (i_cmd.do_write)
                r_dirty[r_sel] <= (r_bricks > 13'(MAX_DIRTY_BRICKS))
                                  ? 13'(MAX_DIRTY_BRICKS) : r_bricks;
            if (i_cmd.clear_run) begin
                r_rev  <= '0;
                r_last <= '0;
            end
            if (i_cmd.rev_update && r_rev != r_rev_in) begin
                r_rev <= r_rev_in;
                r_rr  <= '0;
                for (int k = 0; k < MAX_CASCADES; k++) begin
                    r_next[k]   <= '0;
                    r_passes[k] <= '0;
                end
            end
            if (i_cmd.take_meas) r_cost <= div_q[31:0];
            if (i_cmd.take_avg)  r_cost <= avg_v;
            if (i_cmd.take_bud)  r_budget <= want_c;
            if (i_cmd.scan_hit)  r_rr <= cand_nx;
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
                r_st    <= i_cmd.emit_status;
                r_co    <= '0;
                r_off   <= '0;
                r_cnt   <= '0;
            end
            if (i_cmd.dispatch) begin
                r_valid <= 1'b1;
                r_co    <= r_cand;
                r_off   <= {offs[11:0], 6'd0};
                if (cnt == '0) begin
                    r_st  <= ST_NO_GROUPS;
                    r_cnt <= '0;
                end else begin
                    r_st   <= ST_DISPATCH;
                    r_cnt  <= cnt;
                    r_last <= cnt;
                    if (nsum >= tot) begin
                        r_next[r_cand]   <= '0;
                        r_passes[r_cand] <= r_passes[r_cand] + 6'd1;
                    end else begin
                        r_next[r_cand] <= nsum;
                    end
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_st;
    assign o_cascade      = r_co;
    assign o_probe_offset = r_off;
    assign o_group_count  = r_cnt;

    a_budget_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_budget != '0) else $error("group budget dropped to zero");
    a_passes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_passes[r_rr] <= 6'(PASS_LIMIT)) else $error("pass count overran limit");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.dispatch) |=> r_valid) else $error("result lost");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> !(r_valid && !i_out_ready)) else $error("accept while full");
endmodule

// ----- sv/adaptive_budget_cascade_work_scheduler.sv -----
// Top level of the adaptive budget cascade work scheduler.
// Depends on abcws_pkg, abcws_ctrl, abcws_dp (which holds abcws_div).
//
// Usage: one item enters on the s_axis channel. tuser = req_type: 0 writes
// the dirty brick count of one cascade, 1 is a frame tick that picks a
// cascade round-robin and sizes a dispatch from the measured group cost.
// Every item produces exactly one result on m_axis.
// Flow: a count write or an early-out tick is decided in the decode state,
// which loads the output register. A full tick runs up to two divisions
// (measured cost, budget) on a shared bit-serial divider, the 4:1 average
// by a combinational reciprocal multiply, then a scan of up to 8 cascades,
// one per cycle. Items are processed one at a time; the next item is taken
// once the sequencer is back in idle.
// Configuration: i_cfg_we with i_cfg_idx 0 (cascade count) or 1 (speed
// level); write only while idle.
// Reset (synchronous, active low) clears all cascade tables, revision,
// cost (unmeasured) and sets the budget to one group.
// Stall: the result waits in the output register; a new item is accepted
// only when that register is empty or being drained in the same cycle.
module adaptive_budget_cascade_work_scheduler import abcws_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: cascade_sel[2:0], dirty_bricks[15:3], dirty_revision[79:16],
    //        gpu_time_ns[103:80]
    input  logic [103:0] s_axis_tdata,
    // tuser: req_type[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[2:0], cascade_out[5:3], probe_offset[23:6],
    //        group_count[36:24], zero fill[39:37]
    output logic [39:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [3:0]   i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;
    logic [2:0]  st, co;
    logic [17:0] off;
    logic [12:0] cnt;

    // Sequencer: decode, divider steps, scan, dispatch.
    abcws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: state tables, divider, output register.
    abcws_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (s_axis_tuser[0]),
        .i_cascade_sel    (s_axis_tdata[2:0]),
        .i_dirty_bricks   (s_axis_tdata[15:3]),
        .i_dirty_revision (s_axis_tdata[79:16]),
        .i_gpu_time_ns    (s_axis_tdata[103:80]),
        .o_valid          (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_status         (st),
        .o_cascade        (co),
        .o_probe_offset   (off),
        .o_group_count    (cnt)
    );

    assign m_axis_tdata = {3'b000, cnt, off, co, st};
endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the adaptive budget cascade work scheduler.
// Depends on abcws_pkg and the block's RTL; a built-in predictor or a typed row checks every result.
module tb;
    import abcws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    // Packed from the top bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [12:0] groups;
        logic [17:0] offset;
        logic [2:0]  cascade;
        logic [2:0]  status;
    } sched_res_t;

    // One row of the directed table: either a register write or an item,
    // optionally with a hand-written expected result.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [3:0]  cfg_val;
        bit          tick;
        logic [2:0]  sel;
        logic [12:0] bricks;
        logic [63:0] rev;
        logic [23:0] gpu_ns;
        bit          typed;
        logic [2:0]  exp_status;
    } row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: cascade_sel, dirty_bricks, dirty_revision, gpu_time_ns (low to high)
    logic [103:0] s_axis_tdata = '0;
    // tuser: req_type
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: status, cascade_out, probe_offset, group_count, zero fill (low to high)
    logic [39:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [3:0]   i_cfg_data = '0;

    adaptive_budget_cascade_work_scheduler dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state, mirroring the block's tables and registers.
    logic [3:0]  p_cc;
    logic [1:0]  p_speed;
    logic [12:0] p_dirty [MAX_CASCADES];
    logic [12:0] p_next  [MAX_CASCADES];
    logic [5:0]  p_passes[MAX_CASCADES];
    logic [63:0] p_rev;
    logic [2:0]  p_rr;
    logic [12:0] p_last;
    logic [31:0] p_cost;
    logic [15:0] p_budget;

    sched_res_t pending_results[$];
    int  fails = 0, items_in = 0, results_out = 0, dispatches = 0, converged = 0;
    int  send_idle_pct = 0, recv_stall_pct = 0;
    int  quiet_cycles = 0;

    function automatic sched_res_t schedule_tick(logic [63:0] rev, logic [23:0] gpu_ns);
        sched_res_t r;
        int unsigned cc, cand, chosen, total, offs, cnt;
        logic [63:0] meas, want, lo, hi, tgt;
        bit any, found;
        r = '0;
        cc = (p_cc > MAX_CASCADES) ? MAX_CASCADES : p_cc;
        if (cc == 0) begin
            r.status = ST_NO_GROUPS;
            return r;
        end
        if (rev == 0) begin
            r.status = ST_NO_REV;
            return r;
        end
        any = 0;
        for (int i = 0; i < cc; i++) if (p_dirty[i] != 0) any = 1;
        if (!any) begin
            p_rev = 0;
            p_last = 0;
            r.status = ST_CLEAN;
            return r;
        end
        // New revision: restart every cascade's progress.
        if (p_rev != rev) begin
            p_rev = rev;
            for (int i = 0; i < MAX_CASCADES; i++) begin
                p_next[i] = 0;
                p_passes[i] = 0;
            end
            p_rr = 0;
        end
        // Running cost per group, 4:1 average in UQ24.8.
        if (gpu_ns != 0 && p_last != 0) begin
            meas = ({40'd0, gpu_ns} << 8) / p_last;
            if (p_cost > 0) meas = (64'(p_cost) * 4 + meas) / 5;
            if (meas > 64'hFFFF_FFFF) meas = 64'hFFFF_FFFF;
            p_cost = meas[31:0];
        end
        // Budget from target time, held within half and double of the old one.
        if (p_cost != 0) begin
            case (p_speed)
                2'd0: tgt = 2000000;
                2'd2: tgt = 350000;
                default: tgt = 1000000;
            endcase
            want = (tgt << 8) / p_cost;
            if (want < 1) want = 1;
            lo = p_budget / 2;
            if (lo < 1) lo = 1;
            hi = 64'(p_budget) * 2;
            if (hi < 2) hi = 2;
            if (hi > 65535) hi = 65535;
            if (want < lo) want = lo;
            if (want > hi) want = hi;
            p_budget = want[15:0];
        end
        found = 0;
        chosen = 0;
        for (int i = 0; i < cc; i++) begin
            cand = (p_rr + i) % cc;
            if (!found && p_dirty[cand] > 0 && p_passes[cand] < PASS_LIMIT) begin
                chosen = cand;
                found = 1;
                p_rr = (cand + 1) % cc;
            end
        end
        if (!found) begin
            p_rev = 0;
            p_last = 0;
            r.status = ST_CONVERGED;
            return r;
        end
        // One brick fills exactly one group of probes.
        total = p_dirty[chosen];
        r.cascade = chosen;
        offs = p_next[chosen];
        if (offs > total) offs = total;
        cnt = total - offs;
        if (p_budget < cnt) cnt = p_budget;
        r.offset = 18'(offs * 64);
        if (cnt == 0) begin
            r.status = ST_NO_GROUPS;
            return r;
        end
        p_last = cnt;
        p_next[chosen] = offs + cnt;
        if (offs + cnt >= total) begin
            p_next[chosen] = 0;
            p_passes[chosen]++;
        end
        r.status = ST_DISPATCH;
        r.groups = cnt;
        return r;
    endfunction

    function automatic sched_res_t schedule_item(bit tick, logic [2:0] sel,
                                                 logic [12:0] bricks, logic [63:0] rev,
                                                 logic [23:0] gpu_ns);
        sched_res_t r;
        if (tick) return schedule_tick(rev, gpu_ns);
        r = '0;
        r.status = ST_WRITTEN;
        p_dirty[sel] = (bricks > MAX_DIRTY_BRICKS) ? 13'(MAX_DIRTY_BRICKS) : bricks;
        return r;
    endfunction

    // Offer one item; hold it until accepted, then queue its expected result.
    task automatic send_item(bit tick, logic [2:0] sel, logic [12:0] bricks,
                             logic [63:0] rev, logic [23:0] gpu_ns,
                             bit typed = 0, logic [2:0] typed_status = 0);
        sched_res_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick;
        s_axis_tdata  <= {gpu_ns, rev, bricks, sel};
        do @(posedge i_clk); while (!s_axis_tready);
        r = schedule_item(tick, sel, bricks, rev, gpu_ns);
        if (typed) begin
            r = '0;
            r.status = typed_status;
        end
        pending_results.push_back(r);
        items_in++;
    endtask

    // Drain the block, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CASCADE_COUNT) p_cc = val;
        else p_speed = val[1:0];
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        sched_res_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[36:0];
            results_out++;
            if (got.status == ST_DISPATCH) dispatches++;
            if (got.status == ST_CONVERGED) converged++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fails++;
                end
                if (got.cascade !== want.cascade) begin
                    $error("cascade_out: expected %0d, got %0d", want.cascade, got.cascade);
                    fails++;
                end
                if (got.offset !== want.offset) begin
                    $error("probe_offset: expected %0d, got %0d", want.offset, got.offset);
                    fails++;
                end
                if (got.groups !== want.groups) begin
                    $error("group_count: expected %0d, got %0d", want.groups, got.groups);
                    fails++;
                end
                if (m_axis_tdata[39:37] !== 3'b0) begin
                    $error("zero fill: expected 0, got %0d", m_axis_tdata[39:37]);
                    fails++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    row_t dir_rows[$];

    function automatic row_t item_row(bit tick, logic [2:0] sel, logic [12:0] bricks,
                                      logic [63:0] rev, logic [23:0] gpu_ns,
                                      bit typed = 0, logic [2:0] st = 0);
        row_t r;
        r = '{default: '0};
        r.tick = tick; r.sel = sel; r.bricks = bricks; r.rev = rev; r.gpu_ns = gpu_ns;
        r.typed = typed; r.exp_status = st;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [1:0] idx, logic [3:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.cfg_idx = idx; r.cfg_val = val;
        return r;
    endfunction

    initial begin
        logic [63:0] rev_cur;
        int pick;
        p_cc = 4; p_speed = 1; p_rev = 0; p_rr = 0; p_last = 0; p_cost = 0; p_budget = 1;
        for (int i = 0; i < MAX_CASCADES; i++) begin
            p_dirty[i] = 0; p_next[i] = 0; p_passes[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, saturation, extremes, every register.
        dir_rows.push_back(item_row(1, 0, 0, 0, 0, 1, ST_NO_REV));
        dir_rows.push_back(item_row(1, 0, 0, 7, 0, 1, ST_CLEAN));
        dir_rows.push_back(item_row(0, 0, 13'h1FFF, 0, 0, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(0, 3, 1, '1, '1, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(1, 5, 13'h1555, 7, 0));
        dir_rows.push_back(item_row(1, 0, 0, 7, 24'hFFFFFF));
        dir_rows.push_back(item_row(1, 0, 0, 7, 1000));
        dir_rows.push_back(item_row(1, 0, 0, '1, 1));
        dir_rows.push_back(item_row(1, 2, 13'h0AAA, '1, 500));
        dir_rows.push_back(item_row(0, 0, 0, 0, 0, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(0, 3, 0, 0, 0, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(1, 0, 0, 9, 100, 1, ST_CLEAN));
        dir_rows.push_back(cfg_row(CFG_CASCADE_COUNT, 0));
        dir_rows.push_back(item_row(1, 0, 0, 9, 100, 1, ST_NO_GROUPS));
        dir_rows.push_back(cfg_row(CFG_CASCADE_COUNT, 15));
        dir_rows.push_back(cfg_row(CFG_SPEED_LEVEL, 0));
        dir_rows.push_back(item_row(0, 7, 4096, 0, 0, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(0, 5, 2, 0, 0, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(1, 0, 0, 3, 0));
        dir_rows.push_back(item_row(1, 0, 0, 3, 20));
        dir_rows.push_back(item_row(1, 0, 0, 3, 900000));
        // Shrink a cascade under its own progress.
        dir_rows.push_back(item_row(0, 7, 1, 0, 0, 1, ST_WRITTEN));
        dir_rows.push_back(item_row(1, 0, 0, 3, 4000));
        dir_rows.push_back(item_row(1, 0, 0, 3, 4000));
        dir_rows.push_back(cfg_row(CFG_SPEED_LEVEL, 2));
        dir_rows.push_back(item_row(1, 0, 0, 3, 777));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            else send_item(dir_rows[i].tick, dir_rows[i].sel, dir_rows[i].bricks,
                           dir_rows[i].rev, dir_rows[i].gpu_ns,
                           dir_rows[i].typed, dir_rows[i].exp_status);
        end

        // Random part: eight settings, each under one idling pattern.
        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            write_reg(CFG_CASCADE_COUNT, (seg == 0) ? 4'd1 : (seg == 7) ? 4'd8
                                         : (seg == 5) ? 4'd15 : 4'($urandom_range(1, 8)));
            write_reg(CFG_SPEED_LEVEL, 4'(seg % 4));
            rev_cur = $urandom_range(1, 5);
            for (int n = 0; n < 215; n++) begin
                pick = $urandom_range(99);
                if (pick < 18)
                    send_item(0, 3'($urandom), ($urandom_range(9) == 0) ? 13'($urandom)
                              : 13'($urandom_range(0, 40)), {$urandom, $urandom},
                              24'($urandom));
                else if (pick < 21)
                    send_item(1, 3'($urandom), 13'($urandom), 0, 24'($urandom));
                else if (pick < 24) begin
                    rev_cur = ($urandom_range(1) == 0) ? {$urandom, $urandom}
                                                       : 64'($urandom_range(1, 5));
                    if (rev_cur == 0) rev_cur = 1;
                    send_item(1, 3'($urandom), 13'($urandom), rev_cur, 24'($urandom));
                end else
                    send_item(1, 3'($urandom), 13'($urandom), rev_cur,
                              ($urandom_range(3) == 0) ? 24'($urandom)
                              : 24'($urandom_range(0, 200000)));
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d items, %0d results: %0d dispatches, %0d convergence acks",
                 items_in, results_out, dispatches, converged);
        $display("all idling patterns, cascade counts 0 to 15, every speed level");
        if (fails == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
